/* rtl/markup_to_ansi_color_expander_macros.svh */
// Assertion macros shared by the markup expander modules.
`ifndef MARKUP_TO_ANSI_COLOR_EXPANDER_MACROS_SVH
`define MARKUP_TO_ANSI_COLOR_EXPANDER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define M2A_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define M2A_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

/* rtl/m2a_pkg.sv */
// Types, constants and byte tables of the markup to ANSI color expander.
`timescale 1ns / 1ps

package m2a_pkg;

   // Command queue depth between the classifier and the byte emitter
   localparam int CMD_DEPTH = 4;

   // Run lengths and counter width
   localparam int PREFIX_LEN = 7;
   localparam int RESET_LEN  = 21;
   localparam int RUN_CNT_W  = 5;

   // Character codes
   localparam logic [7:0] TRIG_CHAR  = 8'h40;
   localparam logic [7:0] ESC_CHAR   = 8'h1b;
   localparam logic [7:0] BANG_CHAR  = 8'h21;
   localparam logic [7:0] MINUS_CHAR = 8'h2d;
   localparam logic [7:0] PLUS_CHAR  = 8'h2b;

   // Register word index
   localparam logic REG_OUTPUT_ENABLE = 1'b0;

   typedef enum logic [2:0] {
      CMD_CHAR,
      CMD_AT_CHAR,
      CMD_FG,
      CMD_BG,
      CMD_RESET
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
      logic [2:0]   color;
   } cmd_type;

   // Color letter lookup: {hit, background, palette index}
   function automatic logic [4:0] letter_lookup(input logic [7:0] c);
      logic [4:0] r;
      case (c)
         "K":     r = 5'b10_000;
         "R":     r = 5'b10_001;
         "G":     r = 5'b10_010;
         "Y":     r = 5'b10_011;
         "B":     r = 5'b10_100;
         "M":     r = 5'b10_101;
         "C":     r = 5'b10_110;
         "W":     r = 5'b10_111;
         "k":     r = 5'b11_000;
         "r":     r = 5'b11_001;
         "g":     r = 5'b11_010;
         "y":     r = 5'b11_011;
         "b":     r = 5'b11_100;
         "m":     r = 5'b11_101;
         "c":     r = 5'b11_110;
         "w":     r = 5'b11_111;
         default: r = 5'b00_000;
      endcase
      return r;
   endfunction

   // Length of a whole color sequence: prefix plus code and final 'm'
   function automatic logic [RUN_CNT_W-1:0] color_run_len(input logic [2:0] color);
      logic [RUN_CNT_W-1:0] r;
      case (color)
         3'd0:    r = RUN_CNT_W'(PREFIX_LEN + 2);
         3'd1:    r = RUN_CNT_W'(PREFIX_LEN + 4);
         3'd2:    r = RUN_CNT_W'(PREFIX_LEN + 3);
         3'd3:    r = RUN_CNT_W'(PREFIX_LEN + 4);
         3'd4:    r = RUN_CNT_W'(PREFIX_LEN + 3);
         3'd5:    r = RUN_CNT_W'(PREFIX_LEN + 4);
         3'd6:    r = RUN_CNT_W'(PREFIX_LEN + 2);
         default: r = RUN_CNT_W'(PREFIX_LEN + 3);
      endcase
      return r;
   endfunction

   // Prefix ESC "[38;5;" or ESC "[48;5;"
   function automatic logic [7:0] prefix_byte(input logic [2:0] k, input logic bg);
      logic [7:0] r;
      case (k)
         3'd0:    r = ESC_CHAR;
         3'd1:    r = "[";
         3'd2:    r = bg ? "4" : "3";
         3'd3:    r = "8";
         3'd4:    r = ";";
         3'd5:    r = "5";
         3'd6:    r = ";";
         default: r = ";";
      endcase
      return r;
   endfunction

   // Palette code text, ending in 'm'
   function automatic logic [7:0] code_byte(input logic [2:0] color, input logic [1:0] k);
      logic [7:0] r;
      case ({color, k})
         5'b000_00: r = "0";
         5'b000_01: r = "m";
         5'b001_00: r = "1";
         5'b001_01: r = "9";
         5'b001_10: r = "6";
         5'b001_11: r = "m";
         5'b010_00: r = "4";
         5'b010_01: r = "8";
         5'b010_10: r = "m";
         5'b011_00: r = "2";
         5'b011_01: r = "2";
         5'b011_10: r = "6";
         5'b011_11: r = "m";
         5'b100_00: r = "2";
         5'b100_01: r = "6";
         5'b100_10: r = "m";
         5'b101_00: r = "1";
         5'b101_01: r = "6";
         5'b101_10: r = "3";
         5'b101_11: r = "m";
         5'b110_00: r = "6";
         5'b110_01: r = "m";
         5'b111_00: r = "1";
         5'b111_01: r = "5";
         5'b111_10: r = "m";
         default:   r = "m";
      endcase
      return r;
   endfunction

   // Attribute reset: ESC "[0;38;5;15m" ESC "[48;5;0m"
   function automatic logic [7:0] reset_byte(input logic [RUN_CNT_W-1:0] k);
      logic [7:0] r;
      case (k)
         5'd0:    r = ESC_CHAR;
         5'd1:    r = "[";
         5'd2:    r = "0";
         5'd3:    r = ";";
         5'd4:    r = "3";
         5'd5:    r = "8";
         5'd6:    r = ";";
         5'd7:    r = "5";
         5'd8:    r = ";";
         5'd9:    r = "1";
         5'd10:   r = "5";
         5'd11:   r = "m";
         5'd12:   r = ESC_CHAR;
         5'd13:   r = "[";
         5'd14:   r = "4";
         5'd15:   r = "8";
         5'd16:   r = ";";
         5'd17:   r = "5";
         5'd18:   r = ";";
         5'd19:   r = "0";
         default: r = "m";
      endcase
      return r;
   endfunction

   // Bytes produced by one command
   function automatic logic [RUN_CNT_W-1:0] run_len(input cmd_type cmd);
      logic [RUN_CNT_W-1:0] r;
      case (cmd.kind)
         CMD_CHAR:    r = RUN_CNT_W'(1);
         CMD_AT_CHAR: r = RUN_CNT_W'(2);
         CMD_FG:      r = color_run_len(cmd.color);
         CMD_BG:      r = color_run_len(cmd.color);
         CMD_RESET:   r = RUN_CNT_W'(RESET_LEN);
         default:     r = RUN_CNT_W'(1);
      endcase
      return r;
   endfunction

endpackage

/* rtl/m2a_front.sv */
// Front end: tracks markup state and turns each character into at most one command.
`timescale 1ns / 1ps

module m2a_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept_i,
   input  logic [7:0]       char_i,
   input  logic             output_enable_i,
   output logic             cmd_push_o,
   output m2a_pkg::cmd_type cmd_o
);

   logic       trig_ff;
   logic       trig_in;
   logic       color_ff;
   logic       color_in;
   logic [4:0] letter;

   assign letter = m2a_pkg::letter_lookup(char_i);

   // Classify the character and advance the markup state
   always_comb begin
      trig_in    = trig_ff;
      color_in   = color_ff;
      cmd_push_o = 1'b0;
      cmd_o.kind  = m2a_pkg::CMD_CHAR;
      cmd_o.ch    = char_i;
      cmd_o.color = letter[2:0];
      if (accept_i && output_enable_i) begin
         if (char_i == m2a_pkg::TRIG_CHAR && !trig_ff) begin
            trig_in = 1'b1;
         end else if (trig_ff) begin
            trig_in = 1'b0;
            if (letter[4]) begin
               cmd_push_o = color_ff;
               cmd_o.kind = letter[3] ? m2a_pkg::CMD_BG : m2a_pkg::CMD_FG;
            end else if (char_i == m2a_pkg::BANG_CHAR) begin
               cmd_push_o = 1'b1;
               cmd_o.kind = m2a_pkg::CMD_RESET;
            end else if (char_i == m2a_pkg::MINUS_CHAR) begin
               color_in = 1'b0;
            end else if (char_i == m2a_pkg::PLUS_CHAR) begin
               color_in = 1'b1;
            end else if (char_i == m2a_pkg::TRIG_CHAR) begin
               // doubled trigger gives one literal
               cmd_push_o = 1'b1;
               cmd_o.kind = m2a_pkg::CMD_CHAR;
            end else begin
               cmd_push_o = 1'b1;
               cmd_o.kind = m2a_pkg::CMD_AT_CHAR;
            end
         end else begin
            cmd_push_o = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff  <= 1'b0;
         color_ff <= 1'b1;
      end else begin
         trig_ff  <= trig_in;
         color_ff <= color_in;
      end
   end

endmodule

/* rtl/m2a_cmd_queue.sv */
// Short command queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`include "markup_to_ansi_color_expander_macros.svh"

module m2a_cmd_queue #(
   parameter int Depth = m2a_pkg::CMD_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  m2a_pkg::cmd_type cmd_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic             valid_o,
   output m2a_pkg::cmd_type cmd_o
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   m2a_pkg::cmd_type slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;

   assign full_o  = (count_ff == CntW'(Depth));
   assign valid_o = (count_ff != '0);
   assign cmd_o   = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= cmd_i;
      end
   end

   `M2A_NEVER(a_push_full, push_i && full_o && !pop_i, "queue pushed while full")
   `M2A_NEVER(a_pop_empty, pop_i && !valid_o, "queue popped while empty")
   `M2A_ASSERT(a_fill_up, (push_i && !pop_i) |=> count_ff == $past(count_ff) + 1'b1, "fill count did not grow")

endmodule

/* rtl/m2a_back.sv */
// Back end: expands the head command into bytes through an output register.
`timescale 1ns / 1ps
`include "markup_to_ansi_color_expander_macros.svh"

module m2a_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid_i,
   input  m2a_pkg::cmd_type q_cmd_i,
   output logic             q_pop_o,
   output logic             rsp_valid_o,
   output logic [7:0]       rsp_byte_o,
   output logic             rsp_last_o,
   input  logic             rsp_take_i
);

   localparam int CntW = m2a_pkg::RUN_CNT_W;

   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            valid_ff;
   logic            valid_in;
   logic [7:0]      byte_ff;
   logic            last_ff;
   logic [CntW-1:0] len;
   logic            is_last;
   logic            emit;
   logic [7:0]      byte_sel;
   logic [1:0]      code_idx;

   assign len      = m2a_pkg::run_len(q_cmd_i);
   assign is_last  = (count_ff == len - 1'b1);
   assign emit     = q_valid_i && (!valid_ff || rsp_take_i);
   assign q_pop_o  = emit && is_last;
   assign code_idx = 2'(count_ff - CntW'(m2a_pkg::PREFIX_LEN));

   // Select the byte at the current run position
   always_comb begin
      case (q_cmd_i.kind)
         m2a_pkg::CMD_CHAR: begin
            byte_sel = q_cmd_i.ch;
         end
         m2a_pkg::CMD_AT_CHAR: begin
            byte_sel = (count_ff == '0) ? m2a_pkg::TRIG_CHAR : q_cmd_i.ch;
         end
         m2a_pkg::CMD_FG, m2a_pkg::CMD_BG: begin
            if (count_ff < CntW'(m2a_pkg::PREFIX_LEN)) begin
               byte_sel = m2a_pkg::prefix_byte(count_ff[2:0],
                                               q_cmd_i.kind == m2a_pkg::CMD_BG);
            end else begin
               byte_sel = m2a_pkg::code_byte(q_cmd_i.color, code_idx);
            end
         end
         m2a_pkg::CMD_RESET: begin
            byte_sel = m2a_pkg::reset_byte(count_ff);
         end
         default: begin
            byte_sel = q_cmd_i.ch;
         end
      endcase
   end

   // Advance run position and output valid
   always_comb begin
      count_in = count_ff;
      valid_in = valid_ff;
      if (emit) begin
         count_in = is_last ? '0 : count_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_take_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // Load output payload
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_sel;
         last_ff <= is_last;
      end
   end

   assign rsp_valid_o = valid_ff;
   assign rsp_byte_o  = byte_ff;
   assign rsp_last_o  = last_ff;

   `M2A_ASSERT(a_run_bound, count_ff < CntW'(m2a_pkg::RESET_LEN), "run position out of range")
   `M2A_NEVER(a_idle_count, !q_valid_i && count_ff != '0, "run position set with no command")
   `M2A_ASSERT(a_hold_head, (emit && !is_last) |=> q_valid_i, "head command lost mid run")

endmodule

/* rtl/markup_to_ansi_color_expander.sv */
// The first byte of a character's run reaches the result ports through the command queue
// and the output register, with nothing queued ahead of it.
// Throughput: one character per cycle while each yields one byte and every byte is taken;
// an expansion of up to 21 bytes holds the byte emitter, with up to CmdDepth commands queued.
// Reset (synchronous): output disabled, color on, no pending trigger, queue and output empty.
// Top level of the markup to ANSI color expander.
`timescale 1ns / 1ps

module markup_to_ansi_color_expander #(
   parameter int CmdDepth = m2a_pkg::CMD_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_in,
   // byte output
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_last_of_run,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic             output_enable_ff;
   logic             output_enable_in;
   logic             accept;
   logic             cmd_push;
   m2a_pkg::cmd_type cmd_new;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   m2a_pkg::cmd_type q_cmd;
   logic             rsp_valid;
   logic             rsp_take;

   // Register transfer
   assign pready = 1'b1;
   assign prdata = (paddr[2] == m2a_pkg::REG_OUTPUT_ENABLE) ? {31'b0, output_enable_ff} : '0;

   always_comb begin
      output_enable_in = output_enable_ff;
      if (psel && penable && pwrite && paddr[2] == m2a_pkg::REG_OUTPUT_ENABLE) begin
         output_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_enable_ff <= 1'b0;
      end else begin
         output_enable_ff <= output_enable_in;
      end
   end

   // Channel handshakes
   assign full     = q_full;
   assign accept   = push && !q_full;
   assign empty    = !rsp_valid;
   assign rsp_take = pop && rsp_valid;

   m2a_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept_i        (accept),
      .char_i          (req_char_in),
      .output_enable_i (output_enable_ff),
      .cmd_push_o      (cmd_push),
      .cmd_o           (cmd_new)
   );

   m2a_cmd_queue #(
      .Depth (CmdDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (cmd_push),
      .cmd_i   (cmd_new),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .cmd_o   (q_cmd)
   );

   m2a_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid_i   (q_valid),
      .q_cmd_i     (q_cmd),
      .q_pop_o     (q_pop),
      .rsp_valid_o (rsp_valid),
      .rsp_byte_o  (rsp_byte_out),
      .rsp_last_o  (rsp_last_of_run),
      .rsp_take_i  (rsp_take)
   );

endmodule

/* tb/markup_to_ansi_color_expander_tb.sv */
// Testbench for the markup to ANSI color expander: scoreboarded character stream checks.
`timescale 1ns / 1ps

module markup_to_ansi_color_expander_tb;

   localparam int          RESET_CYCLES = 8;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          LIMIT_CYCLES = 200000;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [2:0]  OUT_EN_ADDR  = 3'(4 * m2a_pkg::REG_OUTPUT_ENABLE);
   localparam logic [2:0]  SPARE_ADDR   = 3'd4;

   typedef struct packed {
      logic [7:0] term_byte;
      logic       run_end;
   } term_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_char_in = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Stimulus and scoreboard state
   logic [7:0]    char_queue[$];
   term_byte_type expected_bytes[$];
   int unsigned   tx_idle_pct = 0;
   int unsigned   rx_idle_pct = 0;
   int unsigned   mismatch_count = 0;
   logic          hold_arm = 1'b0;
   int unsigned   hold_left = 0;

   // Shadow of the block's registers and markup state
   logic        sink_enabled = 1'b0;
   logic        trigger_seen = 1'b0;
   logic        color_on = 1'b1;

   string palette_letters = "KRGYBMCWkrgybmcw";
   string palette_codes[8] = '{"0m", "196m", "48m", "226m", "26m", "163m", "6m", "15m"};
   string fg_prefix = "\033[38;5;";
   string bg_prefix = "\033[48;5;";
   string attr_reset_seq = "\033[0;38;5;15m\033[48;5;0m";

   markup_to_ansi_color_expander u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_char_in     (req_char_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_last_of_run (rsp_last_of_run),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #1 clock = ~clock;

   function automatic void emit_term_byte(input logic [7:0] b);
      expected_bytes.push_back('{term_byte: b, run_end: 1'b0});
   endfunction

   function automatic void emit_text(input string s);
      for (int i = 0; i < s.len(); i++) emit_term_byte(s[i]);
   endfunction

   function automatic int palette_slot(input logic [7:0] c);
      for (int i = 0; i < palette_letters.len(); i++)
         if (palette_letters[i] == c) return i;
      return -1;
   endfunction

   // Work out the terminal bytes one accepted character yields
   function automatic void expand_char(input logic [7:0] c);
      int slot;
      int start_size;
      start_size = expected_bytes.size();
      if (!sink_enabled) return;
      if (c == m2a_pkg::TRIG_CHAR && !trigger_seen) begin
         trigger_seen = 1'b1;
         return;
      end
      if (trigger_seen) begin
         trigger_seen = 1'b0;
         slot = palette_slot(c);
         if (slot >= 0) begin
            if (color_on) begin
               emit_text(slot >= 8 ? bg_prefix : fg_prefix);
               emit_text(palette_codes[slot % 8]);
            end
         end else if (c == m2a_pkg::BANG_CHAR) begin
            emit_text(attr_reset_seq);
         end else if (c == m2a_pkg::MINUS_CHAR) begin
            color_on = 1'b0;
         end else if (c == m2a_pkg::PLUS_CHAR) begin
            color_on = 1'b1;
         end else begin
            if (c != m2a_pkg::TRIG_CHAR) emit_term_byte(m2a_pkg::TRIG_CHAR);
            emit_term_byte(c);
         end
      end else begin
         emit_term_byte(c);
      end
      // Mark the final byte of this character's run
      if (expected_bytes.size() > start_size)
         expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
   endfunction

   function automatic void report_mismatch(input string what, input term_byte_type exp_b,
                                           input term_byte_type act_b);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $realtime, what, exp_b.term_byte, exp_b.run_end,
                  act_b.term_byte, act_b.run_end);
   endfunction

   // Drive characters from the pending queue; predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) expand_char(req_char_in);
         if (!push || !full) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               push        <= 1'b1;
               req_char_in <= char_queue.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Count down a long receiver hold-off once armed
   always @(posedge clock) begin
      if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Take output bytes and compare against the oldest expectation
   always @(posedge clock) begin
      term_byte_type got;
      term_byte_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = '{term_byte: rsp_byte_out, run_end: rsp_last_of_run};
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected output byte", '0, got);
            end else begin
               want = expected_bytes.pop_front();
               if (got.term_byte !== want.term_byte || got.run_end !== want.run_end)
                  report_mismatch("output byte mismatch", want, got);
            end
         end
         pop <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == OUT_EN_ADDR) sink_enabled = data[0];
   endtask

   // Wait until every character is sent and every byte received, then settle
   task automatic wait_idle();
      do @(negedge clock);
      while (!(char_queue.size() == 0 && !push && expected_bytes.size() == 0));
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
   endtask

   // Mostly well-formed markup with random content, some plain noise
   task automatic queue_markup(input int count);
      int added;
      int pick;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(palette_letters[$urandom_range(15)]);
            added += 2;
         end else if (pick < 38) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(m2a_pkg::BANG_CHAR);
            added += 2;
         end else if (pick < 43) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(m2a_pkg::MINUS_CHAR);
            added += 2;
         end else if (pick < 52) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(m2a_pkg::PLUS_CHAR);
            added += 2;
         end else if (pick < 57) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            added += 2;
         end else if (pick < 65) begin
            char_queue.push_back(m2a_pkg::TRIG_CHAR);
            char_queue.push_back(8'($urandom_range(255)));
            added += 2;
         end else begin
            char_queue.push_back(8'($urandom_range(255)));
            added += 1;
         end
      end
   endtask

   initial begin
      #(2 * LIMIT_CYCLES);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (reset);
      tx_idle_pct = 9;
      rx_idle_pct = 48;

      // Output disabled after reset: drop everything, trigger stays clear
      queue_text("A@");
      wait_idle();
      csr_write(OUT_EN_ADDR, 32'h0000_0001);
      csr_write(SPARE_ADDR, 32'h0000_0000);

      // Directed markup: byte extremes, every markup form, color off and on
      char_queue.push_back(8'h00);
      char_queue.push_back(8'hff);
      queue_text("@K@w@R@!@@@Z");
      queue_text("@-@G@!@q@+");
      wait_idle();

      // Random markup, ending with a trigger left pending
      queue_markup(90);
      char_queue.push_back(m2a_pkg::TRIG_CHAR);
      wait_idle();

      // Disable the sink with upper bits set; dropped input keeps state
      csr_write(OUT_EN_ADDR, 32'hffff_fffe);
      for (int i = 0; i < 8; i++) char_queue.push_back(8'($urandom_range(255)));
      wait_idle();
      csr_write(OUT_EN_ADDR, 32'h8000_0001);

      tx_idle_pct = 48;
      rx_idle_pct = 9;
      queue_markup(95);
      wait_idle();

      // No idling; hold the receiver off so the block backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_markup(95);
      @(posedge clock);
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      wait_idle();

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
